FILE: design/lin_rx_pkg.sv
// types and constants shared by the lin slave frame receiver
package lin_rx_pkg;

    localparam logic [7:0] BREAK_BYTE = 8'h00;
    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] ID_MASK    = 8'h3F;
    localparam int         DATA_LEN   = 8;
    localparam int         IDX_W      = $clog2(DATA_LEN);
    localparam int         CNT_W      = $clog2(DATA_LEN + 1);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_BREAK    = 3'd1,
        PH_SYNC     = 3'd2,
        PH_PID      = 3'd3,
        PH_DATA     = 3'd4,
        PH_CHECKSUM = 3'd5
    } phase_t;

    typedef enum logic {
        CMD_BREAK = 1'b0,
        CMD_BYTE  = 1'b1
    } command_t;

    typedef struct packed {
        logic       command;
        logic [7:0] byte_value;
    } rx_item_t;

    typedef struct packed {
        logic [5:0] frame_id;
        logic [7:0] protected_id;
        logic [7:0] checksum_byte;
        logic [7:0] data_0;
        logic [7:0] data_1;
        logic [7:0] data_2;
        logic [7:0] data_3;
        logic [7:0] data_4;
        logic [7:0] data_5;
        logic [7:0] data_6;
        logic [7:0] data_7;
    } rx_result_t;

endpackage

FILE: design/lin_slave_frame_receiver_top.sv
// lin slave frame receiver: break and byte items in, complete frames out
// Takes one item (a break or a received byte) per clock cycle. Breaks, sync and identifier
// bytes, and data bytes only update the phase, byte count and identifier registers and the
// eight-entry data buffer. The checksum byte loads the result register, which holds the frame
// until it is taken. In the checksum phase any item, the checksum byte or a break, is held off
// while an earlier frame still waits in that register and result_ready is low. In every other
// phase items never wait. Frames appear in the cycle after their checksum byte is accepted.
module lin_slave_frame_receiver_top
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  lin_rx_pkg::rx_item_t   item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output lin_rx_pkg::rx_result_t result
);
    import lin_rx_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [CNT_W-1:0]   byte_count_reg;
    logic [CNT_W-1:0]   byte_count_next;
    logic [7:0]         id_hold_reg;
    logic [7:0]         id_hold_next;
    logic [7:0]         data_reg [DATA_LEN];
    logic               data_we;
    logic               result_valid_reg;
    logic               result_valid_next;
    rx_result_t         result_reg;
    rx_result_t         result_next;
    logic               accept;
    logic               emit;

    assign item_ready   = !(result_valid_reg && !result_ready && phase_reg == PH_CHECKSUM);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            byte_count_reg   <= '0;
            id_hold_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            id_hold_reg      <= id_hold_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_reg[byte_count_reg[IDX_W-1:0]] <= item.byte_value;
        end
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        id_hold_next    = id_hold_reg;
        data_we         = 1'b0;
        emit            = 1'b0;
        if (accept)
        begin
            if (item.command == CMD_BREAK)
            begin
                phase_next      = PH_BREAK;
                byte_count_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_BREAK:
                    begin
                        if (item.byte_value == BREAK_BYTE)
                            phase_next = PH_SYNC;
                        else if (item.byte_value == SYNC_BYTE)
                            phase_next = PH_PID;
                        else
                            phase_next = PH_IDLE;
                    end
                    PH_SYNC:
                    begin
                        phase_next = (item.byte_value == SYNC_BYTE) ? PH_PID : PH_IDLE;
                    end
                    PH_PID:
                    begin
                        id_hold_next    = item.byte_value;
                        byte_count_next = '0;
                        phase_next      = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        data_we         = 1'b1;
                        byte_count_next = byte_count_reg + 1'b1;
                        if (byte_count_next >= CNT_W'(DATA_LEN))
                            phase_next = PH_CHECKSUM;
                    end
                    PH_CHECKSUM:
                    begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result_next.frame_id      = 6'(id_hold_reg & ID_MASK);
        result_next.protected_id  = id_hold_reg;
        result_next.checksum_byte = item.byte_value;
        result_next.data_0        = data_reg[0];
        result_next.data_1        = data_reg[1];
        result_next.data_2        = data_reg[2];
        result_next.data_3        = data_reg[3];
        result_next.data_4        = data_reg[4];
        result_next.data_5        = data_reg[5];
        result_next.data_6        = data_reg[6];
        result_next.data_7        = data_reg[7];
    end

    always_comb
    begin
        if (emit)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    // a new frame only follows a checksum byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(phase_reg) == PH_CHECKSUM)
        else $error("frame emitted outside checksum phase");

    // data count never runs past the buffer while collecting
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> byte_count_reg < CNT_W'(DATA_LEN))
        else $error("data count out of range");

    // checksum phase only with a full buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CHECKSUM |-> byte_count_reg == CNT_W'(DATA_LEN))
        else $error("checksum phase without eight data bytes");

    // a break always restarts framing
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.command == CMD_BREAK |=> phase_reg == PH_BREAK && byte_count_reg == '0)
        else $error("break did not restart framing");

    // a pending frame is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready |-> !emit)
        else $error("pending frame overwritten");

endmodule
